/* hdl/dsp_pkg.sv */
`default_nettype none
package dsp_pkg;
   localparam int MAX_NODE_COUNT = 1024;
   localparam int MAX_EDGE_COUNT = 4096;
   localparam int WEIGHT_BITS = 32;
   localparam int NODE_BITS = $clog2(MAX_NODE_COUNT);
   localparam int EDGE_BITS = $clog2(MAX_EDGE_COUNT);
   localparam int ID_BITS = 11;
   localparam int DIST_BITS = 48;
   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_QUERY = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   // node scratch entry: reached, settled, distance
   localparam int NODE_WORD = DIST_BITS + 2;
   localparam int EDGE_WORD = 2 * NODE_BITS + WEIGHT_BITS;
endpackage
`default_nettype wire

/* hdl/dsp_ram.sv */
`default_nettype none
module dsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* hdl/dijkstra_shortest_path.sv */
`default_nettype none
// Dijkstra shortest path over a flat edge store. A query with a source or
// target outside 1..n answers in the cycle after it is taken. A valid query
// first runs a clear pass over the node scratch memory. Then, for each
// settled node, it runs a scan for the minimum and a relax pass over all
// stored edges. In that pass an edge that leaves another node is read and
// checked. An edge that leaves the settled node is read, then its
// destination is read, read again and written back. The pass ends with one
// more edge step that finds no edge left. A last scan finds no node, and the
// final state reads the target. Each memory has one read port, so every
// read-modify-write runs serially. One result beat comes per query. The
// next request is taken only once the result beat has been accepted downstream.
module dijkstra_shortest_path (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // cmd[1:0], from_node[12:2], to_node[23:13], edge_weight[55:24]
   input  wire logic [55:0] req_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [10:0] csr_data,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // reachable[0], path_length[48:1], edges_dropped[49]
   output logic [55:0]      rsp_tdata
);
   import dsp_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0, S_INIT = 3'd1, S_SCAN = 3'd2,
      S_EREAD = 3'd3, S_EWAIT = 3'd4, S_VREAD = 3'd5, S_VWAIT = 3'd6, S_FINAL = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [ID_BITS-1:0] ncfg_ff;
   logic [EDGE_BITS:0] stored_ff, stored_in;
   logic drop_ff, drop_in;
   logic [NODE_BITS-1:0] src_ff, src_in, tgt_ff, tgt_in;
   logic [NODE_BITS:0] idx_ff, idx_in;
   logic [EDGE_BITS:0] eidx_ff, eidx_in;
   logic found_ff, found_in;
   logic [NODE_BITS-1:0] u_ff, u_in;
   logic [DIST_BITS-1:0] ud_ff, ud_in, bd_ff, bd_in;
   logic [DIST_BITS-1:0] cand_ff, cand_in;
   logic [NODE_BITS-1:0] v_ff, v_in;
   logic out_v_ff, out_v_in;
   logic [49:0] out_d_ff, out_d_in;

   logic [NODE_BITS:0] n_use;
   logic [1:0] cmd;
   logic [ID_BITS-1:0] a_id, b_id;
   logic [WEIGHT_BITS-1:0] w;
   logic a_ok, b_ok;

   logic nw_en; logic [NODE_BITS-1:0] nw_addr, nr_addr;
   logic [NODE_WORD-1:0] nw_data, nr_data;
   logic ew_en; logic [EDGE_BITS-1:0] ew_addr, er_addr;
   logic [EDGE_WORD-1:0] ew_data, er_data;

   dsp_ram #(.WIDTH(NODE_WORD), .DEPTH(MAX_NODE_COUNT)) u_node (
      .clock(clock), .wr_en(nw_en), .wr_addr(nw_addr), .wr_data(nw_data),
      .rd_addr(nr_addr), .rd_data(nr_data));
   dsp_ram #(.WIDTH(EDGE_WORD), .DEPTH(MAX_EDGE_COUNT)) u_edge (
      .clock(clock), .wr_en(ew_en), .wr_addr(ew_addr), .wr_data(ew_data),
      .rd_addr(er_addr), .rd_data(er_data));

   assign cmd = req_tdata[1:0];
   assign a_id = req_tdata[12:2];
   assign b_id = req_tdata[23:13];
   assign w = req_tdata[24 +: WEIGHT_BITS];
   assign csr_ready = 1'b1;
   assign req_tready = (state_ff == S_IDLE) && !out_v_ff;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = {6'd0, out_d_ff};

   // saturate node count to 1..MAX_NODE_COUNT
   always_comb begin
      if (ncfg_ff == '0) n_use = (NODE_BITS+1)'(1);
      else if ({1'b0, ncfg_ff} > 12'(MAX_NODE_COUNT)) n_use = (NODE_BITS+1)'(MAX_NODE_COUNT);
      else n_use = (NODE_BITS+1)'(ncfg_ff);
   end
   assign a_ok = a_id != '0 && {1'b0, a_id} <= 12'(n_use);
   assign b_ok = b_id != '0 && {1'b0, b_id} <= 12'(n_use);

   // edge fields as read
   logic [NODE_BITS-1:0] e_src, e_dst;
   logic [WEIGHT_BITS-1:0] e_w;
   assign {e_w, e_dst, e_src} = er_data;
   logic [DIST_BITS:0] sum;
   assign sum = {1'b0, ud_ff} + (DIST_BITS+1)'(e_w);

   // node word fields
   logic n_reached, n_settled;
   logic [DIST_BITS-1:0] n_dist;
   assign {n_reached, n_settled, n_dist} = nr_data;

   always_comb begin
      state_in = state_ff; stored_in = stored_ff; drop_in = drop_ff;
      src_in = src_ff; tgt_in = tgt_ff; idx_in = idx_ff; eidx_in = eidx_ff;
      found_in = found_ff; u_in = u_ff; ud_in = ud_ff; bd_in = bd_ff;
      cand_in = cand_ff; v_in = v_ff;
      out_v_in = out_v_ff && !rsp_tready; out_d_in = out_d_ff;
      nw_en = 1'b0; nw_addr = idx_ff[NODE_BITS-1:0]; nw_data = '0;
      nr_addr = idx_ff[NODE_BITS-1:0];
      ew_en = 1'b0; ew_addr = stored_ff[EDGE_BITS-1:0];
      ew_data = {w, b_id[NODE_BITS-1:0] - 1'b1, a_id[NODE_BITS-1:0] - 1'b1};
      er_addr = eidx_ff[EDGE_BITS-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               case (cmd)
                  CMD_ADD: begin
                     if (stored_ff >= (EDGE_BITS+1)'(MAX_EDGE_COUNT) || !a_ok || !b_ok)
                        drop_in = 1'b1;
                     else begin
                        ew_en = 1'b1;
                        stored_in = stored_ff + 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     stored_in = '0; drop_in = 1'b0;
                  end
                  CMD_QUERY: begin
                     if (!a_ok || !b_ok) begin
                        out_v_in = 1'b1; out_d_in = {drop_ff, 48'd0, 1'b0};
                     end else begin
                        src_in = a_id[NODE_BITS-1:0] - 1'b1;
                        tgt_in = b_id[NODE_BITS-1:0] - 1'b1;
                        idx_in = '0; state_in = S_INIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_INIT: begin
            nw_en = 1'b1;
            nw_data = {idx_ff[NODE_BITS-1:0] == src_ff, 1'b0, {DIST_BITS{1'b0}}};
            idx_in = idx_ff + 1'b1;
            if (idx_ff + 1'b1 == n_use) begin
               idx_in = '0; found_in = 1'b0; state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // read issued at idx, data for idx-1 arrives now
            nr_addr = idx_ff[NODE_BITS-1:0];
            if (idx_ff != '0) begin
               if (n_reached && !n_settled && (!found_ff || n_dist < bd_ff)) begin
                  found_in = 1'b1; u_in = NODE_BITS'(idx_ff - 1'b1); bd_in = n_dist;
               end
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == n_use) begin
               if (!found_in) state_in = S_FINAL;
               else begin
                  nw_en = 1'b1; nw_addr = u_in;
                  nw_data = {1'b1, 1'b1, bd_in};
                  ud_in = bd_in; eidx_in = '0; state_in = S_EREAD;
               end
            end
         end
         S_EREAD: begin
            if (eidx_ff == stored_ff) begin
               idx_in = '0; found_in = 1'b0; state_in = S_SCAN;
            end else state_in = S_EWAIT;
         end
         S_EWAIT: begin
            eidx_in = eidx_ff + 1'b1;
            if (e_src == u_ff && {1'b0, e_dst} < n_use) begin
               v_in = e_dst;
               cand_in = sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];
               nr_addr = e_dst;
               state_in = S_VWAIT;
            end else state_in = S_EREAD;
         end
         S_VWAIT: begin
            nr_addr = v_ff;
            state_in = S_VREAD;
         end
         S_VREAD: begin
            if (!n_settled && (!n_reached || cand_ff < n_dist)) begin
               nw_en = 1'b1; nw_addr = v_ff; nw_data = {1'b1, 1'b0, cand_ff};
            end
            state_in = S_EREAD;
         end
         S_FINAL: begin
            // target read issued in previous cycle held by nr_addr
            nr_addr = tgt_ff;
            if (idx_ff == '0) begin
               out_v_in = 1'b1;
               out_d_in = {drop_ff, n_reached ? n_dist : 48'd0, n_reached};
               state_in = S_IDLE;
            end else idx_in = '0;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; ncfg_ff <= 11'd1; stored_ff <= '0; drop_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; stored_ff <= stored_in; drop_ff <= drop_in;
         out_v_ff <= out_v_in;
         if (csr_valid && csr_ready) ncfg_ff <= csr_data;
      end
      src_ff <= src_in; tgt_ff <= tgt_in; idx_ff <= idx_in; eidx_ff <= eidx_in;
      found_ff <= found_in; u_ff <= u_in; ud_ff <= ud_in; bd_ff <= bd_in;
      cand_ff <= cand_in; v_ff <= v_in; out_d_ff <= out_d_in;
   end

`ifndef SYNTHESIS
   a_store_bound: assert property (@(posedge clock) disable iff (reset)
      stored_ff <= (EDGE_BITS+1)'(MAX_EDGE_COUNT)) else $error("edge count overflow");
   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready) else $error("ready while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[48:1] == '0) else $error("bad length");
`endif
endmodule
`default_nettype wire
